/* sv/ncl_pkg.sv */
`timescale 1ns / 1ps
package ncl_pkg;

  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_DIMS     = 8;
  localparam int DEF_COORD_BITS   = 16;

  localparam int NUM_COORD_FIELDS = 8;
  localparam int CENTRE_IDX_W     = 4;
  localparam int LABEL_W          = 5;
  localparam int NCL_W            = 5;
  localparam int NDIM_W           = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 5;

  localparam logic [NCL_W-1:0]  NCL_RESET  = 5'd3;
  localparam logic [NDIM_W-1:0] NDIM_RESET = 4'd1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 2'd1;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  // index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // width of a count that can hold n itself
  function automatic int cnt_w(input int n);
    return $clog2(n + 1);
  endfunction

  typedef struct packed {
    logic capture;   // latch voxel, clear best
    logic load_we;   // write centre from input word
    logic issue;     // read one centre into the distance pipe
    logic out_load;  // move label into output register
  } ncl_cmd_t;

  typedef struct packed {
    logic busy;      // distance pipe holds work
    logic out_free;  // output register can take a word
  } ncl_sts_t;

endpackage

/* sv/ncl_item_if.sv */
`timescale 1ns / 1ps
interface ncl_item_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [3:0]            centre_index;
  logic                  in_mask;
  logic [COORD_BITS-1:0] coord_0;
  logic [COORD_BITS-1:0] coord_1;
  logic [COORD_BITS-1:0] coord_2;
  logic [COORD_BITS-1:0] coord_3;
  logic [COORD_BITS-1:0] coord_4;
  logic [COORD_BITS-1:0] coord_5;
  logic [COORD_BITS-1:0] coord_6;
  logic [COORD_BITS-1:0] coord_7;

  modport source (output valid, mode, centre_index, in_mask, coord_0, coord_1, coord_2,
                  coord_3, coord_4, coord_5, coord_6, coord_7, input ready);
  modport sink (input valid, mode, centre_index, in_mask, coord_0, coord_1, coord_2,
                coord_3, coord_4, coord_5, coord_6, coord_7, output ready);
endinterface

/* sv/ncl_result_if.sv */
`timescale 1ns / 1ps
interface ncl_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] label;

  modport source (output valid, label, input ready);
  modport sink (input valid, label, output ready);
endinterface

/* sv/ncl_cfg_if.sv */
`timescale 1ns / 1ps
interface ncl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/nearest_centroid_labeler.sv */
`timescale 1ns / 1ps
// Load word: centre written at the accept edge, no result.
// Classify word: the k centres used (k = clusters used) enter the distance pipe one
// per cycle; no new word is taken until the label is loaded into the output register.
// Masked voxel or k = 0: no distance pass; label 0 goes straight to the output register.
// Reset (rst, synchronous): controller idle, pipe and output empty,
// num_clusters = 3, num_dims = 1. The centre store is not cleared.
module nearest_centroid_labeler import ncl_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = DEF_MAX_DIMS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic          clk,
  input  logic          rst,
  ncl_item_if.sink      item,
  ncl_result_if.source  result,
  ncl_cfg_if.sink       cfg
);

  localparam int CNT_W  = cnt_w(MAX_CLUSTERS);
  localparam int CIDX_W = idx_w(MAX_CLUSTERS);
  localparam int DIM_W  = cnt_w(MAX_DIMS);

  logic [NCL_W-1:0]  num_clusters;
  logic [NDIM_W-1:0] num_dims;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= NCL_RESET;
      num_dims     <= NDIM_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_NUM_CLUSTERS) begin
        num_clusters <= cfg.data[NCL_W-1:0];
      end
      if (cfg.index == REG_NUM_DIMS) begin
        num_dims <= cfg.data[NDIM_W-1:0];
      end
    end
  end

  logic [CNT_W-1:0] k;
  logic [DIM_W-1:0] dims;

  assign k    = (32'(num_clusters) > 32'(MAX_CLUSTERS)) ? CNT_W'(MAX_CLUSTERS)
                                                        : CNT_W'(num_clusters);
  assign dims = (32'(num_dims) > 32'(MAX_DIMS)) ? DIM_W'(MAX_DIMS) : DIM_W'(num_dims);

  logic [COORD_BITS-1:0] coords [NUM_COORD_FIELDS];

  assign coords[0] = item.coord_0;
  assign coords[1] = item.coord_1;
  assign coords[2] = item.coord_2;
  assign coords[3] = item.coord_3;
  assign coords[4] = item.coord_4;
  assign coords[5] = item.coord_5;
  assign coords[6] = item.coord_6;
  assign coords[7] = item.coord_7;

  ncl_cmd_t          cmd;
  ncl_sts_t          sts;
  logic [CIDX_W-1:0] issue_addr;

  ncl_ctrl #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_mode    (item.mode),
    .item_in_mask (item.in_mask),
    .item_ready   (item.ready),
    .k            (k),
    .sts          (sts),
    .cmd          (cmd),
    .issue_addr   (issue_addr)
  );

  ncl_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .issue_addr   (issue_addr),
    .sts          (sts),
    .centre_index (item.centre_index),
    .coords       (coords),
    .dims         (dims),
    .result       (result)
  );

endmodule

/* sv/ncl_ram.sv */
`timescale 1ns / 1ps
module ncl_ram import ncl_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [idx_w(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [idx_w(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ncl_dp.sv */
`timescale 1ns / 1ps
module ncl_dp import ncl_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = DEF_MAX_DIMS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ncl_cmd_t                        cmd,
  input  logic [idx_w(MAX_CLUSTERS)-1:0]  issue_addr,
  output ncl_sts_t                        sts,
  input  logic [CENTRE_IDX_W-1:0]         centre_index,
  input  logic [COORD_BITS-1:0]           coords [NUM_COORD_FIELDS],
  input  logic [cnt_w(MAX_DIMS)-1:0]      dims,
  ncl_result_if.source                    result
);

  localparam int CIDX_W = idx_w(MAX_CLUSTERS);
  localparam int DIM_W  = cnt_w(MAX_DIMS);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + $clog2(MAX_DIMS);

  logic [COORD_BITS-1:0] vox [MAX_DIMS];
  logic [COORD_BITS-1:0] rd  [MAX_DIMS];
  logic                  we;
  logic [CIDX_W-1:0]     waddr;

  assign we    = cmd.load_we && (32'(centre_index) < 32'(MAX_CLUSTERS));
  assign waddr = CIDX_W'(centre_index);

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    ncl_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (MAX_CLUSTERS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (coords[d]),
      .raddr (issue_addr),
      .rdata (rd[d])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        vox[d] <= coords[d];
      end
    end
  end

  // pipe: ram read -> |diff| -> square -> sum -> compare
  logic              v1, v2, v3, v4;
  logic [CIDX_W-1:0] t1, t2, t3, t4;
  logic [COORD_BITS-1:0] mag_c [MAX_DIMS];
  logic [COORD_BITS-1:0] mag2  [MAX_DIMS];
  logic [SQ_W-1:0]       sq3   [MAX_DIMS];
  logic [DIST_W-1:0]     sum_c;
  logic [DIST_W-1:0]     dist4;

  always_comb begin
    logic signed [COORD_BITS:0] diff;
    for (int d = 0; d < MAX_DIMS; d++) begin
      diff = $signed({vox[d][COORD_BITS-1], vox[d]}) - $signed({rd[d][COORD_BITS-1], rd[d]});
      if (DIM_W'(d) >= dims) begin
        mag_c[d] = '0;
      end else if (diff[COORD_BITS]) begin
        mag_c[d] = COORD_BITS'(-diff);
      end else begin
        mag_c[d] = COORD_BITS'(diff);
      end
    end
  end

  always_comb begin
    sum_c = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum_c = sum_c + DIST_W'(sq3[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    t1 <= issue_addr;
    t2 <= t1;
    t3 <= t2;
    t4 <= t3;
    for (int d = 0; d < MAX_DIMS; d++) begin
      mag2[d] <= mag_c[d];
      sq3[d]  <= SQ_W'(mag2[d]) * SQ_W'(mag2[d]);
    end
    dist4 <= sum_c;
  end

  logic              have_best;
  logic [CIDX_W-1:0] best_idx;
  logic [DIST_W-1:0] best_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (cmd.capture) begin
      have_best <= 1'b0;
    end else if (v4 && (t4 == '0 || dist4 < best_dist)) begin
      have_best <= 1'b1;
    end
  end

  // strict less-than keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (v4 && (t4 == '0 || dist4 < best_dist)) begin
      best_idx  <= t4;
      best_dist <= dist4;
    end
  end

  logic [LABEL_W-1:0] label_c;
  assign label_c = have_best ? LABEL_W'(32'(best_idx) + 32'd1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.label <= label_c;
    end
  end

  assign sts.busy     = v1 | v2 | v3 | v4;
  assign sts.out_free = !result.valid || result.ready;

endmodule

/* sv/ncl_ctrl.sv */
`timescale 1ns / 1ps
module ncl_ctrl import ncl_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_mode,
  input  logic                            item_in_mask,
  output logic                            item_ready,
  input  logic [cnt_w(MAX_CLUSTERS)-1:0]  k,
  input  ncl_sts_t                        sts,
  output ncl_cmd_t                        cmd,
  output logic [idx_w(MAX_CLUSTERS)-1:0]  issue_addr
);

  localparam int CNT_W  = cnt_w(MAX_CLUSTERS);
  localparam int CIDX_W = idx_w(MAX_CLUSTERS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign issue_addr = cnt[CIDX_W-1:0];

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_we = accept && (item_mode == MODE_LOAD);
        if (accept && item_mode == MODE_CLASSIFY) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          // masked voxel or no centres: label stays 0
          state_next  = (item_in_mask && k != '0) ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt_next == k) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    sts.busy |-> (state == S_RUN || state == S_DRAIN))
    else $error("distance pipe busy outside a classify pass");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (cnt < k))
    else $error("centre read beyond cluster count");

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && sts.out_free) |=> (state == S_IDLE))
    else $error("result not handed off");

  a_masked_short: assert property (@(posedge clk) disable iff (rst)
    (accept && item_mode == MODE_CLASSIFY && !item_in_mask) |=> (state == S_DONE))
    else $error("masked voxel entered the distance pass");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import ncl_pkg::*;

  localparam int CENTRES       = DEF_MAX_CLUSTERS;
  localparam int DIMS          = DEF_MAX_DIMS;
  localparam int CW            = DEF_COORD_BITS;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 112;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef logic [DIMS-1:0][CW-1:0] coord_vec_t;

  typedef struct packed {
    logic                    mode;
    logic [CENTRE_IDX_W-1:0] centre_index;
    logic                    in_mask;
    coord_vec_t              coord;
  } voxel_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_CFG, ROW_FILL} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    voxel_word_t            word;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    bit                     fixed;
    logic [LABEL_W-1:0]     label;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ncl_item_if #(.COORD_BITS(CW)) item_bus ();
  ncl_result_if                  result_bus ();
  ncl_cfg_if                     cfg_bus ();

  nearest_centroid_labeler #(
    .MAX_CLUSTERS(CENTRES),
    .MAX_DIMS    (DIMS),
    .COORD_BITS  (CW)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus),
    .cfg   (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's state
  coord_vec_t         centre_mem [CENTRES];
  logic [NCL_W-1:0]   clusters_cfg = NCL_RESET;
  logic [NDIM_W-1:0]  dims_cfg     = NDIM_RESET;

  logic [LABEL_W-1:0] pending_labels [$];
  logic [LABEL_W-1:0] want_label;
  int                 mismatches = 0;
  int                 idle_cycles = 0;

  bit item_up       = 1'b0;
  bit in_quiet      = 1'b0;
  bit out_quiet     = 1'b0;
  bit hold_off_req  = 1'b0;

  function automatic int pick_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic coord_vec_t splat(input logic [CW-1:0] v);
    coord_vec_t r;
    for (int d = 0; d < DIMS; d++) r[d] = v;
    return r;
  endfunction

  function automatic coord_vec_t rand_coords();
    coord_vec_t r;
    for (int d = 0; d < DIMS; d++) r[d] = CW'($urandom);
    return r;
  endfunction

  // label of the nearest centre, exact squared distance, ties to lowest index
  function automatic logic [LABEL_W-1:0] nearest_label(input voxel_word_t w);
    int                 k_used;
    int                 d_used;
    longint             diff;
    logic [63:0]        sq_sum;
    logic [63:0]        best;
    logic [LABEL_W-1:0] lab;
    k_used = (clusters_cfg > CENTRES) ? CENTRES : int'(clusters_cfg);
    d_used = (dims_cfg > DIMS) ? DIMS : int'(dims_cfg);
    lab = '0;
    best = '0;
    if (!w.in_mask) return '0;
    for (int c = 0; c < k_used; c++) begin
      sq_sum = '0;
      for (int d = 0; d < d_used; d++) begin
        diff = longint'($signed(w.coord[d])) - longint'($signed(centre_mem[c][d]));
        sq_sum += 64'(diff * diff);
      end
      if (c == 0 || sq_sum < best) begin
        best = sq_sum;
        lab = LABEL_W'(c + 1);
      end
    end
    return lab;
  endfunction

  function automatic voxel_word_t random_word(input int k_used);
    voxel_word_t w;
    int          style;
    int          src;
    w.mode = ($urandom_range(0, 99) < 25) ? MODE_LOAD : MODE_CLASSIFY;
    w.centre_index = CENTRE_IDX_W'($urandom_range(0, CENTRES - 1));
    w.in_mask = 1'($urandom_range(0, 1));
    style = $urandom_range(0, 9);
    src = $urandom_range(0, ((k_used > 0) ? k_used : CENTRES) - 1);
    for (int d = 0; d < DIMS; d++) begin
      if (style < 3)
        w.coord[d] = CW'($urandom);
      else if (style < 5)
        w.coord[d] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      else if (style < 7)
        w.coord[d] = centre_mem[src][d];  // exact copy: makes ties
      else
        w.coord[d] = centre_mem[src][d] + CW'($urandom_range(0, 8)) - CW'(4);
    end
    if (w.mode == MODE_CLASSIFY) w.in_mask = ($urandom_range(0, 9) != 0);
    return w;
  endfunction

  function automatic stim_row_t word_row(input logic mode, input int idx, input logic mask,
                                         input coord_vec_t coord, input bit fixed,
                                         input int label);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.word.mode = mode;
    r.word.centre_index = CENTRE_IDX_W'(idx);
    r.word.in_mask = mask;
    r.word.coord = coord;
    r.reg_index = '0;
    r.reg_data = '0;
    r.fixed = fixed;
    r.label = LABEL_W'(label);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t r;
    r = word_row(MODE_LOAD, 0, 1'b0, '0, 1'b0, 0);
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_data = CFG_DATA_W'(data);
    return r;
  endfunction

  task automatic send_word(input voxel_word_t w, input int gap, input bit fixed,
                           input logic [LABEL_W-1:0] label);
    if (gap > 0) begin
      if (item_up) item_bus.valid <= 1'b0;
      item_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.mode         <= w.mode;
    item_bus.centre_index <= w.centre_index;
    item_bus.in_mask      <= w.in_mask;
    item_bus.coord_0      <= w.coord[0];
    item_bus.coord_1      <= w.coord[1];
    item_bus.coord_2      <= w.coord[2];
    item_bus.coord_3      <= w.coord[3];
    item_bus.coord_4      <= w.coord[4];
    item_bus.coord_5      <= w.coord[5];
    item_bus.coord_6      <= w.coord[6];
    item_bus.coord_7      <= w.coord[7];
    item_bus.valid        <= 1'b1;
    item_up = 1'b1;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    if (w.mode == MODE_LOAD)
      centre_mem[w.centre_index] = w.coord;
    else
      pending_labels.push_back(fixed ? label : nearest_label(w));
  endtask

  // stop offering, let every label come back, then let the pipe go quiet
  task automatic drain();
    if (item_up) item_bus.valid <= 1'b0;
    item_up = 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == REG_NUM_CLUSTERS)
      clusters_cfg = data;
    else if (idx == REG_NUM_DIMS)
      dims_cfg = data[NDIM_W-1:0];
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_row(input stim_row_t r);
    voxel_word_t w;
    case (r.kind)
      ROW_WORD: begin
        send_word(r.word, pick_gap(1'b0), r.fixed, r.label);
      end
      ROW_CFG: begin
        drain();
        write_reg(r.reg_index, r.reg_data);
      end
      ROW_FILL: begin
        // load every centre from the given index up with random content
        for (int c = r.word.centre_index; c < CENTRES; c++) begin
          w = r.word;
          w.centre_index = CENTRE_IDX_W'(c);
          w.in_mask = 1'($urandom_range(0, 1));
          w.coord = rand_coords();
          send_word(w, pick_gap(1'b0), 1'b0, '0);
        end
      end
      default: ;
    endcase
  endtask

  // label checker
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_labels.size() == 0) begin
        mismatches++;
        $display("%0t: label expected none actual %0d", $time, result_bus.label);
      end else begin
        want_label = pending_labels.pop_front();
        if (result_bus.label !== want_label) begin
          mismatches++;
          $display("%0t: label expected %0d actual %0d", $time, want_label, result_bus.label);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // label sink: random stalls, one long hold-off on request
  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = pick_gap(out_quiet);
      end
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
    end
  end

  initial begin
    stim_row_t   plan [$];
    voxel_word_t w;
    int          phase_k [6] = '{16, 1, 31, 4, 0, 17};
    int          phase_d [6] = '{8, 1, 15, 3, 0, 8};
    int          k;
    int          nd;

    item_bus.valid        <= 1'b0;
    item_bus.mode         <= MODE_LOAD;
    item_bus.centre_index <= '0;
    item_bus.in_mask      <= 1'b0;
    item_bus.coord_0      <= '0;
    item_bus.coord_1      <= '0;
    item_bus.coord_2      <= '0;
    item_bus.coord_3      <= '0;
    item_bus.coord_4      <= '0;
    item_bus.coord_5      <= '0;
    item_bus.coord_6      <= '0;
    item_bus.coord_7      <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;

    // reset settings: 3 centres, 1 dim
    plan.push_back(word_row(MODE_CLASSIFY, 5, 1'b0, splat(16'h7FFF), 1'b1, 0));
    plan.push_back(word_row(MODE_LOAD, 0, 1'b0, splat(16'h8000), 1'b0, 0));
    plan.push_back(word_row(MODE_LOAD, 1, 1'b1, splat(16'h7FFF), 1'b0, 0));
    plan.push_back(word_row(MODE_LOAD, 2, 1'b0, splat(16'h0000), 1'b0, 0));
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, splat(16'h8000), 1'b1, 1));
    plan.push_back(word_row(MODE_CLASSIFY, 15, 1'b1, splat(16'h7FFF), 1'b1, 2));
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, splat(16'h0001), 1'b1, 3));
    // -16384 sits halfway between centre 0 and centre 2: lower index wins
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, splat(16'hC000), 1'b1, 1));
    plan.push_back(word_row(MODE_LOAD, 3, 1'b0, '0, 1'b0, 0));
    plan[$].kind = ROW_FILL;
    plan.push_back(cfg_row(REG_NUM_CLUSTERS, 31));
    plan.push_back(cfg_row(REG_NUM_DIMS, 8));
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, rand_coords(), 1'b0, 0));
    plan.push_back(word_row(MODE_CLASSIFY, 9, 1'b1, splat(16'h8000), 1'b1, 1));
    plan.push_back(word_row(MODE_LOAD, 15, 1'b1, splat(16'h1234), 1'b0, 0));
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, splat(16'h1234), 1'b1, 16));
    plan.push_back(cfg_row(REG_NUM_DIMS, 15));
    plan.push_back(word_row(MODE_CLASSIFY, 3, 1'b1, rand_coords(), 1'b0, 0));
    plan.push_back(cfg_row(REG_NUM_CLUSTERS, 0));
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, rand_coords(), 1'b1, 0));
    plan.push_back(cfg_row(REG_NUM_CLUSTERS, 16));
    plan.push_back(cfg_row(REG_NUM_DIMS, 0));
    plan.push_back(word_row(MODE_CLASSIFY, 0, 1'b1, rand_coords(), 1'b1, 1));
    plan.push_back(cfg_row(REG_SPARE_2, 31));
    plan.push_back(cfg_row(REG_SPARE_3, 10));
    plan.push_back(cfg_row(REG_NUM_DIMS, 1));
    plan.push_back(cfg_row(REG_NUM_CLUSTERS, 2));
    plan.push_back(word_row(MODE_CLASSIFY, 15, 1'b1, splat(16'h7FFF), 1'b1, 2));
    plan.push_back(word_row(MODE_CLASSIFY, 15, 1'b0, splat(16'h8000), 1'b1, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) run_row(plan[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 6) begin
        k = phase_k[p];
        nd = phase_d[p];
      end else begin
        k = $urandom_range(1, 16);
        nd = $urandom_range(0, 15);
      end
      write_reg(REG_NUM_CLUSTERS, CFG_DATA_W'(k));
      write_reg(REG_NUM_DIMS, CFG_DATA_W'(nd));
      in_quiet = (p == 3) || ($urandom_range(0, 4) == 0);
      out_quiet = (p != 3) && ($urandom_range(0, 4) == 0);
      // keep offering voxels while the sink holds off
      if (p == 3) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        w = random_word((k > CENTRES) ? CENTRES : k);
        if (p == 3) w.mode = MODE_CLASSIFY;
        send_word(w, pick_gap(in_quiet), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0 && pending_labels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
